>>> sv/ptts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; imported by every module of the block.
package ptts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int TAG_W         = 8;
  localparam int PER_W         = 16;
  localparam int TICK_W        = 8;
  localparam int QDEPTH        = 2;
  localparam logic [TICK_W-1:0] TICK_RST = 8'd65;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_START  = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DUE    = 1'b1;

  // One queued request from the front end
  typedef struct packed {
    op_t               op;
    logic [TAG_W-1:0]  tag;
    logic [PER_W-1:0]  period;
  } req_t;

  // Divider command and answer
  typedef struct packed {
    logic              start;
    logic [PER_W-1:0]  dvd;
    logic [PER_W-1:0]  dvs;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [PER_W-1:0]  quo;
    logic [PER_W-1:0]  rem;
  } div_rsp_t;

endpackage

>>> sv/ptts_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the function code and queues them.
// Depends on ptts_pkg.
module ptts_front import ptts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [TAG_W-1:0]  in_task_tag,
  input  logic [PER_W-1:0]  in_period_ms,
  output logic              req_valid,
  output req_t              req,
  input  logic              req_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  req_t             q_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;
  req_t             in_req;

  // Classify the incoming function code
  always_comb begin
    in_req.op     = op_t'(in_func);
    in_req.tag    = in_task_tag;
    in_req.period = in_period_ms;
  end

  assign in_stall  = (cnt_r == CNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign req_valid = (cnt_r != '0);
  assign pop       = req_pop && req_valid;
  assign req       = q_r[rd_ptr_r];

  // Hold queued payloads
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_req;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/ptts_divu.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for GCD, factor and modulo work.
// Depends on ptts_pkg.
module ptts_divu import ptts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_cmd_t cmd,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(PER_W + 1);

  logic [PER_W-1:0]  rem_r;
  logic [PER_W-1:0]  quo_r;
  logic [PER_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [PER_W:0]    shifted;
  logic [PER_W:0]    diff;

  assign shifted = {rem_r, quo_r[PER_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  // Shift in one dividend bit and try the subtraction
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= '0;
      quo_r <= cmd.dvd;
      dvs_r <= cmd.dvs;
    end else if (busy_r) begin
      if (!diff[PER_W]) begin
        rem_r <= diff[PER_W-1:0];
        quo_r <= {quo_r[PER_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[PER_W-1:0];
        quo_r <= {quo_r[PER_W-2:0], 1'b0};
      end
    end
  end

  // Count the steps and flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(PER_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> sv/ptts_back.sv
`timescale 1ns / 1ps
// Back end: task table, sequencer for add/remove/start/tick and result register.
// Depends on ptts_pkg and ptts_divu.
module ptts_back import ptts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TICK_W-1:0] max_tick,
  input  logic              req_valid,
  input  req_t              req,
  output logic              req_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [1:0]        out_status,
  output logic [TAG_W-1:0]  out_due_tag,
  output logic [TICK_W-1:0] out_tick_ms,
  output logic              out_last
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_GCD_INIT, S_GCD_NEXT, S_EUC, S_EUC_W, S_RED, S_RED_W,
    S_DV, S_DV_W, S_TK, S_TK_W, S_TK_EMIT, S_TK_FIN
  } state_t;

  state_t            state_r;
  logic [PER_W-1:0]  period_r  [MAX_TASKS];
  logic [TAG_W-1:0]  ident_r   [MAX_TASKS];
  logic [PER_W-1:0]  divisor_r [MAX_TASKS];
  logic [CNT_W-1:0]  count_r;
  logic [PER_W-1:0]  counter_r;
  logic [TICK_W-1:0] tick_r;
  logic [CNT_W-1:0]  idx_r;
  logic [PER_W-1:0]  g_r;
  logic [PER_W-1:0]  y_r;
  logic [PER_W-1:0]  f_r;
  logic [TAG_W-1:0]  pend_r;
  logic              pend_v_r;
  status_t           status_r;
  div_cmd_t          div_cmd_r;
  div_rsp_t          div_rsp;

  logic              out_valid_r;
  logic              out_kind_r;
  status_t           out_status_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [TICK_W-1:0] out_tick_r;
  logic              out_last_r;

  logic              emit_ok;
  logic [TICK_W-1:0] lim;
  logic [IDX_W-1:0]  idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [CNT_W-1:0]  count_dec;

  ptts_divu u_divu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd_r),
    .rsp   (div_rsp)
  );

  assign emit_ok   = !out_valid_r || !out_stall;
  assign lim       = (max_tick == '0) ? TICK_W'(1) : max_tick;
  assign idx       = idx_r[IDX_W-1:0];
  assign count_dec = count_r - 1'b1;
  assign req_pop   = (state_r == S_IDLE);

  // Find the first live entry whose tag matches
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = MAX_TASKS - 1; k >= 0; k--) begin
      if ((CNT_W'(k) < count_r) && (ident_r[k] == req.tag)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  // Sequencer, table and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      counter_r   <= '0;
      tick_r      <= TICK_RST;
      pend_v_r    <= 1'b0;
      div_cmd_r   <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        divisor_r[k] <= '0;
      end
    end else begin
      div_cmd_r.start <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            unique case (req.op)
              OP_ADD: begin
                if (req.period == '0) begin
                  status_r <= ST_INVALID;
                end else if (count_r >= CNT_W'(MAX_TASKS)) begin
                  status_r <= ST_FULL;
                end else begin
                  period_r[count_r[IDX_W-1:0]]  <= req.period;
                  ident_r[count_r[IDX_W-1:0]]   <= req.tag;
                  divisor_r[count_r[IDX_W-1:0]] <= '0;
                  count_r  <= count_r + 1'b1;
                  status_r <= ST_OK;
                end
                state_r <= S_RESP;
              end
              OP_REMOVE: begin
                if (!hit) begin
                  status_r <= ST_NOTFOUND;
                  state_r  <= S_RESP;
                end else begin
                  // Close the gap: later entries move down by one
                  for (int k = 0; k < MAX_TASKS - 1; k++) begin
                    if ((IDX_W'(k) >= hit_idx) && (CNT_W'(k + 1) < count_r)) begin
                      period_r[k]  <= period_r[k+1];
                      ident_r[k]   <= ident_r[k+1];
                      divisor_r[k] <= divisor_r[k+1];
                    end
                  end
                  divisor_r[count_dec[IDX_W-1:0]] <= '0;
                  count_r  <= count_dec;
                  status_r <= ST_OK;
                  state_r  <= (count_dec == '0) ? S_RESP : S_GCD_INIT;
                end
              end
              OP_START: begin
                if (count_r == '0) begin
                  status_r <= ST_INVALID;
                  state_r  <= S_RESP;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_GCD_INIT;
                end
              end
              OP_TICK: begin
                counter_r <= counter_r + 1'b1;
                idx_r     <= '0;
                pend_v_r  <= 1'b0;
                state_r   <= S_TK;
              end
            endcase
          end
        end
        S_RESP: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_STATUS;
            out_status_r <= status_r;
            out_tag_r    <= '0;
            out_tick_r   <= tick_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_GCD_INIT: begin
          g_r     <= period_r[0];
          idx_r   <= CNT_W'(1);
          state_r <= S_GCD_NEXT;
        end
        S_GCD_NEXT: begin
          if (idx_r >= count_r) begin
            f_r     <= PER_W'(2);
            state_r <= S_RED;
          end else begin
            y_r     <= period_r[idx];
            state_r <= S_EUC;
          end
        end
        S_EUC: begin
          if (y_r == '0) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_GCD_NEXT;
          end else begin
            div_cmd_r <= '{start: 1'b1, dvd: g_r, dvs: y_r};
            state_r   <= S_EUC_W;
          end
        end
        S_EUC_W: begin
          if (div_rsp.done) begin
            g_r     <= y_r;
            y_r     <= div_rsp.rem;
            state_r <= S_EUC;
          end
        end
        S_RED: begin
          if (g_r > PER_W'(lim)) begin
            div_cmd_r <= '{start: 1'b1, dvd: g_r, dvs: f_r};
            state_r   <= S_RED_W;
          end else begin
            // Clamp to at least one ms
            g_r     <= (g_r == '0) ? PER_W'(1) : g_r;
            tick_r  <= (g_r == '0) ? TICK_W'(1) : g_r[TICK_W-1:0];
            idx_r   <= '0;
            state_r <= S_DV;
          end
        end
        S_RED_W: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              g_r <= div_rsp.quo;
            end else begin
              f_r <= f_r + 1'b1;
            end
            state_r <= S_RED;
          end
        end
        S_DV: begin
          if (idx_r >= count_r) begin
            state_r <= S_RESP;
          end else begin
            div_cmd_r <= '{start: 1'b1, dvd: period_r[idx], dvs: g_r};
            state_r   <= S_DV_W;
          end
        end
        S_DV_W: begin
          if (div_rsp.done) begin
            divisor_r[idx] <= div_rsp.quo;
            idx_r          <= idx_r + 1'b1;
            state_r        <= S_DV;
          end
        end
        S_TK: begin
          if (idx_r >= count_r) begin
            state_r <= pend_v_r ? S_TK_FIN : S_IDLE;
          end else if (divisor_r[idx] == '0) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            div_cmd_r <= '{start: 1'b1, dvd: counter_r, dvs: divisor_r[idx]};
            state_r   <= S_TK_W;
          end
        end
        S_TK_W: begin
          if (div_rsp.done) begin
            if (div_rsp.rem != '0) begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_TK;
            end else if (!pend_v_r) begin
              pend_r   <= ident_r[idx];
              pend_v_r <= 1'b1;
              idx_r    <= idx_r + 1'b1;
              state_r  <= S_TK;
            end else begin
              state_r <= S_TK_EMIT;
            end
          end
        end
        S_TK_EMIT: begin
          // Release the held notice; the new one takes its place
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_DUE;
            out_status_r <= ST_OK;
            out_tag_r    <= pend_r;
            out_tick_r   <= tick_r;
            out_last_r   <= 1'b0;
            pend_r       <= ident_r[idx];
            idx_r        <= idx_r + 1'b1;
            state_r      <= S_TK;
          end
        end
        S_TK_FIN: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_DUE;
            out_status_r <= ST_OK;
            out_tag_r    <= pend_r;
            out_tick_r   <= tick_r;
            out_last_r   <= 1'b1;
            pend_v_r     <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_status  = out_status_r;
  assign out_due_tag = out_tag_r;
  assign out_tick_ms = out_tick_r;
  assign out_last    = out_last_r;

endmodule

>>> sv/periodic_task_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// Periodic task tick scheduler, top level. Add and failed requests pass from the idle state
// to the response state, which registers the result. Recompute runs on one shared divider,
// one call per Euclid step, factor trial and per-task divisor. A tick calls the divider once per
// task with a nonzero divisor. A two-entry request queue takes items while the sequencer works.
// Synchronous active-low reset: empty table, counter 0, tick and limit register 65.
module periodic_task_tick_scheduler_unit import ptts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [TAG_W-1:0]  in_task_tag,
  input  logic [PER_W-1:0]  in_period_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [1:0]        out_status,
  output logic [TAG_W-1:0]  out_due_tag,
  output logic [TICK_W-1:0] out_tick_ms,
  output logic              out_last
);

  logic [TICK_W-1:0] max_tick_r;
  logic              req_valid;
  logic              req_pop;
  req_t              req;

  // Hold the tick limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tick_r <= TICK_RST;
    end else if (cfg_we) begin
      max_tick_r <= cfg_wdata;
    end
  end

  ptts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_task_tag  (in_task_tag),
    .in_period_ms (in_period_ms),
    .req_valid    (req_valid),
    .req          (req),
    .req_pop      (req_pop)
  );

  ptts_back #(
    .MAX_TASKS (MAX_TASKS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_tick    (max_tick_r),
    .req_valid   (req_valid),
    .req         (req),
    .req_pop     (req_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_status  (out_status),
    .out_due_tag (out_due_tag),
    .out_tick_ms (out_tick_ms),
    .out_last    (out_last)
  );

`ifndef SYNTH
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_STATUS) |-> (out_due_tag == '0) && out_last)
    else $error("status result with tag or without last");

  a_due_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DUE) |-> (out_status == ST_OK))
    else $error("due notice with nonzero status");

  a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tick_ms != '0))
    else $error("zero tick length reported");
`endif

endmodule
